FILE: rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and codes of the client watchdog table: command kinds,
// decoded operations, result status codes, the command word struct that
// passes from the queue to the table engine and the result word struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wdt_pkg;

  localparam int IdW   = 16;
  localparam int TypeW = 8;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_KICK   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef enum logic [3:0] {
    OP_TICK   = 4'b0001,
    OP_ADD    = 4'b0010,
    OP_REMOVE = 4'b0100,
    OP_KICK   = 4'b1000
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IdW-1:0]   id;
    logic [TypeW-1:0] ctype;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IdW-1:0]   id;
    logic [TypeW-1:0] ctype;
    logic             last;
  } res_t;

endpackage

FILE: rtl/wdt_front.sv
// ----------------------------------------------------------------------------
// wdt_front
// Command front end: accepts command words, decodes the kind into an
// operation and holds them in a two-entry queue for the table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_kind,
  input  logic [15:0]         in_client_id,
  input  logic [7:0]          in_client_type,
  output logic                cmd_valid,
  output wdt_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);
  import wdt_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.id    = in_client_id;
    dec.ctype = in_client_type;
    unique case (in_kind)
      KIND_TICK:   dec.op = OP_TICK;
      KIND_ADD:    dec.op = OP_ADD;
      KIND_REMOVE: dec.op = OP_REMOVE;
      default:     dec.op = OP_KICK;
    endcase
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: rtl/wdt_engine.sv
// ----------------------------------------------------------------------------
// wdt_engine
// Table engine: owns the client table memory, alive flags and entry count,
// and walks the table one entry a cycle for tick, kick and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdt_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  wdt_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output wdt_pkg::res_t  res
);
  import wdt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = IdW + TypeW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TICK  = 6'b000010,
    S_KICK  = 6'b000100,
    S_FIND  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic                 rv_r, rv_nxt;
  logic [AW-1:0]        ridx_r, ridx_nxt;
  logic [MAX_ENTRIES-1:0] alive_r, alive_nxt;
  logic [IdW-1:0]       cmd_id_r, cmd_id_nxt;
  logic [DW-1:0]        pend_r, pend_nxt;
  logic                 have_pend_r, have_pend_nxt;
  logic                 res_valid_r, res_valid_nxt;
  res_t                 res_r, res_nxt;

  logic [DW-1:0]        mem [MAX_ENTRIES];
  logic [DW-1:0]        rd_data_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 more, done;

  assign more      = (ptr_r < count_r);
  assign done      = !rv_r && !more;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    alive_nxt     = alive_r;
    cmd_id_nxt    = cmd_id_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = ridx_r - AW'(1);
    mem_wdata     = rd_data_r;

    if (state_r != S_IDLE && more) begin
      ptr_nxt  = ptr_r + CW'(1);
      rv_nxt   = 1'b1;
      ridx_nxt = ptr_r[AW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          ptr_nxt       = '0;
          have_pend_nxt = 1'b0;
          cmd_id_nxt    = cmd.id;
          unique case (cmd.op)
            OP_TICK: begin
              if (count_r == '0) begin
                res_valid_nxt = 1'b1;
                res_nxt       = '{status: ST_NONE, id: '0, ctype: '0, last: 1'b1};
              end else begin
                state_nxt = S_TICK;
              end
            end
            OP_ADD: begin
              res_valid_nxt = 1'b1;
              if (count_r < MAX_CNT) begin
                mem_we     = 1'b1;
                mem_waddr  = count_r[AW-1:0];
                mem_wdata  = {cmd.id, cmd.ctype};
                alive_nxt[count_r[AW-1:0]] = 1'b1;
                count_nxt  = count_r + CW'(1);
                res_nxt    = '{status: ST_OK, id: cmd.id, ctype: '0, last: 1'b1};
              end else begin
                res_nxt    = '{status: ST_FULL, id: cmd.id, ctype: '0, last: 1'b1};
              end
            end
            OP_REMOVE: state_nxt = S_FIND;
            default:   state_nxt = S_KICK;
          endcase
        end
      end
      S_TICK: begin
        if (rv_r) begin
          if (!alive_r[ridx_r]) begin
            if (have_pend_r) begin
              res_valid_nxt = 1'b1;
              res_nxt = '{status: ST_EXPIRED, id: pend_r[DW-1:TypeW],
                          ctype: pend_r[TypeW-1:0], last: 1'b0};
            end
            pend_nxt      = rd_data_r;
            have_pend_nxt = 1'b1;
          end else begin
            alive_nxt[ridx_r] = 1'b0;
          end
        end
        if (done) begin
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (have_pend_r) begin
            res_nxt = '{status: ST_EXPIRED, id: pend_r[DW-1:TypeW],
                        ctype: pend_r[TypeW-1:0], last: 1'b1};
          end else begin
            res_nxt = '{status: ST_NONE, id: '0, ctype: '0, last: 1'b1};
          end
        end
      end
      S_KICK: begin
        if (rv_r && rd_data_r[DW-1:TypeW] == cmd_id_r) begin
          alive_nxt[ridx_r] = 1'b1;
        end
        if (done) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, id: cmd_id_r, ctype: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      S_FIND: begin
        if (rv_r && rd_data_r[DW-1:TypeW] == cmd_id_r) begin
          state_nxt = S_SHIFT;
          ptr_nxt   = CW'(ridx_r) + CW'(1);
          rv_nxt    = 1'b0;
        end else if (done) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_NOTFOUND, id: cmd_id_r, ctype: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (rv_r) begin
          mem_we = 1'b1;
          alive_nxt[ridx_r - AW'(1)] = alive_r[ridx_r];
        end
        if (done) begin
          count_nxt     = count_r - CW'(1);
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, id: cmd_id_r, ctype: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      alive_r     <= '0;
      have_pend_r <= 1'b0;
      res_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      alive_r     <= alive_nxt;
      have_pend_r <= have_pend_nxt;
      res_valid_r <= res_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r   <= ridx_nxt;
    cmd_id_r <= cmd_id_nxt;
    pend_r   <= pend_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r[AW-1:0]];
  end

endmodule

FILE: rtl/multi_client_watchdog_table.sv
// ----------------------------------------------------------------------------
// multi_client_watchdog_table
// Heartbeat watchdog over a compact table of monitored clients.
// ----------------------------------------------------------------------------
// Command channel: a word (in_kind, in_client_id, in_client_type) is taken on
// a clock edge with start high and busy low. Kinds: tick, add, remove, kick.
// Words land in a two-entry queue; busy rises only when that queue is full.
// Result channel: each result word shows on out_* for one cycle with
// out_valid high; out_last marks the final word of a command. The receiver
// cannot stall, so results never back up.
// Work per command, with n entries in the table:
//   add              write of the new entry behind the last one, if not full
//   kick             walk of all n entries, marking each match alive
//   remove           search, then shift of later entries
//   tick             walk of all n entries (none on an empty table),
//                    one expiry word per cycle at most
// Each command first passes through the queue. The table memory, with one
// write port and one read port, is read one entry a cycle.
// Reset empties the table and clears the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_client_watchdog_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_client_id,
  input  logic [7:0]  in_client_type,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_expired_id,
  output logic [7:0]  out_expired_type,
  output logic        out_last
);
  import wdt_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  wdt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_client_id   (in_client_id),
    .in_client_type (in_client_type),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  wdt_engine #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_expired_id   = res.id;
  assign out_expired_type = res.ctype;
  assign out_last         = res.last;

endmodule

FILE: rtl/wdt_checker.sv
// ----------------------------------------------------------------------------
// wdt_checker
// Port-level checks of the watchdog table result stream, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [15:0] out_expired_id,
  input logic [7:0]  out_expired_type,
  input logic        out_last
);
  import wdt_pkg::*;

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_single_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EXPIRED |-> out_last)
    else $error("non-expiry result not marked last");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_expired_id == 16'd0 &&
      out_expired_type == 8'd0)
    else $error("none result carries a client");

  a_reply_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_FULL ||
      out_status == ST_NOTFOUND) |-> out_expired_type == 8'd0)
    else $error("request reply carries a type");

  a_known_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_FULL ||
      out_status == ST_NOTFOUND || out_status == ST_EXPIRED ||
      out_status == ST_NONE)
    else $error("unknown status code");

endmodule

bind multi_client_watchdog_table wdt_checker u_chk (.*);

FILE: tb/watchdog_table_checker.sv
// ----------------------------------------------------------------------------
// watchdog_table_checker
// Passive monitor of the client watchdog table. It keeps its own copy of the
// client table, predicts the result words of every accepted command and
// compares each result word, field by field, with the oldest one predicted.
// Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module watchdog_table_checker #(
  parameter int TableDepth = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_client_id,
  input  logic [7:0]  in_client_type,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_expired_id,
  input  logic [7:0]  out_expired_type,
  input  logic        out_last,
  output int          mismatches,
  output int          awaited,
  output int          words_checked,
  output int          expiries_seen,
  output int          full_seen
);

  import wdt_pkg::*;

  logic [15:0] client_ids[TableDepth];
  logic [7:0]  client_types[TableDepth];
  logic        client_alive[TableDepth];
  int          clients_held;
  res_t        due_words[$];

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_word(input logic [2:0] status, input logic [15:0] id,
                           input logic [7:0] ctype, input logic last);
    res_t w;
    w.status = status;
    w.id     = id;
    w.ctype  = ctype;
    w.last   = last;
    due_words.push_back(w);
  endtask

  task automatic run_command(input logic [1:0] kind, input logic [15:0] id,
                             input logic [7:0] ctype);
    int   expired;
    int   hit;
    res_t tail;
    expired = 0;
    hit     = -1;
    case (kind)
      KIND_TICK: begin
        for (int i = 0; i < clients_held; i++) begin
          if (!client_alive[i]) begin
            push_word(ST_EXPIRED, client_ids[i], client_types[i], 1'b0);
            expired++;
          end else begin
            client_alive[i] = 1'b0;
          end
        end
        if (expired == 0) begin
          push_word(ST_NONE, '0, '0, 1'b1);
        end else begin
          tail = due_words.pop_back();
          tail.last = 1'b1;
          due_words.push_back(tail);
        end
      end
      KIND_ADD: begin
        if (clients_held < TableDepth) begin
          client_ids[clients_held]   = id;
          client_types[clients_held] = ctype;
          client_alive[clients_held] = 1'b1;
          clients_held++;
          push_word(ST_OK, id, '0, 1'b1);
        end else begin
          push_word(ST_FULL, id, '0, 1'b1);
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < clients_held; i++) begin
          if (hit < 0 && client_ids[i] == id) hit = i;
        end
        if (hit < 0) begin
          push_word(ST_NOTFOUND, id, '0, 1'b1);
        end else begin
          // shift later entries down over the removed one
          for (int i = hit; i + 1 < clients_held; i++) begin
            client_ids[i]   = client_ids[i+1];
            client_types[i] = client_types[i+1];
            client_alive[i] = client_alive[i+1];
          end
          clients_held--;
          push_word(ST_OK, id, '0, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < clients_held; i++) begin
          if (client_ids[i] == id) client_alive[i] = 1'b1;
        end
        push_word(ST_OK, id, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      clients_held = 0;
      for (int i = 0; i < TableDepth; i++) client_alive[i] = 1'b0;
      due_words.delete();
    end else begin
      if (start && !busy) run_command(in_kind, in_client_id, in_client_type);
      if (out_valid) begin
        words_checked++;
        if (due_words.size() == 0) begin
          flag_mismatch($sformatf("result word status %0d id %h with none awaited",
                                  out_status, out_expired_id));
        end else begin
          want = due_words.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_expired_id !== want.id)
            flag_mismatch($sformatf("id %h, want %h", out_expired_id, want.id));
          if (out_expired_type !== want.ctype)
            flag_mismatch($sformatf("type %h, want %h", out_expired_type, want.ctype));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", out_last, want.last));
          if (want.status == ST_EXPIRED) expiries_seen++;
          if (want.status == ST_FULL) full_seen++;
        end
      end
    end
    awaited = due_words.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the client watchdog table. A short directed run
// covers the empty-table tick, extreme ids and types, duplicates, absent ids
// and expiry, then random traffic in four mixes fills, churns and drains the
// table with bursty command timing. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import wdt_pkg::*;

  localparam int TableDepth = 16;
  localparam int IdleLimit  = 2000;
  localparam int PhaseItems = 36;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [15:0] in_client_id;
  logic [7:0]  in_client_type;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_expired_id;
  logic [7:0]  out_expired_type;
  logic        out_last;

  int mismatches;
  int awaited;
  int words_checked;
  int expiries_seen;
  int full_seen;

  int          burst_left;
  bit          no_gaps;
  int          words_sent;
  int          idle_cycles;
  logic [15:0] id_pool[6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_client_watchdog_table #(.MAX_ENTRIES(TableDepth)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_client_id     (in_client_id),
    .in_client_type   (in_client_type),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_expired_id   (out_expired_id),
    .out_expired_type (out_expired_type),
    .out_last         (out_last)
  );

  watchdog_table_checker #(.TableDepth(TableDepth)) table_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_client_id     (in_client_id),
    .in_client_type   (in_client_type),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_expired_id   (out_expired_id),
    .out_expired_type (out_expired_type),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .words_checked    (words_checked),
    .expiries_seen    (expiries_seen),
    .full_seen        (full_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("stalled for %0d cycles with %0d words awaited", idle_cycles, awaited);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(input logic [1:0] kind, input logic [15:0] id,
                              input logic [7:0] ctype);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(6);
      burst_left = $urandom_range(10, 1);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start          = 1'b1;
    in_kind        = kind;
    in_client_id   = id;
    in_client_type = ctype;
    // hold the word until the block takes it
    do @(posedge clk); while (busy);
    burst_left--;
    words_sent++;
  endtask

  function automatic logic [15:0] pick_id();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return id_pool[$urandom_range(5)];
  endfunction

  function automatic logic [1:0] pick_kind(input int phase);
    int tick_pct[4]   = '{10, 25, 15, 35};
    int add_pct[4]    = '{60, 25, 10, 20};
    int remove_pct[4] = '{10, 25, 50, 10};
    int r;
    r = $urandom_range(99);
    if (r < tick_pct[phase]) return KIND_TICK;
    if (r < tick_pct[phase] + add_pct[phase]) return KIND_ADD;
    if (r < tick_pct[phase] + add_pct[phase] + remove_pct[phase]) return KIND_REMOVE;
    return KIND_KICK;
  endfunction

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_TICK;
    in_client_id   = '0;
    in_client_type = '0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    words_sent     = 0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 6; i++) id_pool[i] = 16'($urandom);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_command(KIND_TICK,   16'h0000, 8'h00);
    send_command(KIND_ADD,    16'h0000, 8'hFF);
    send_command(KIND_ADD,    16'hFFFF, 8'h00);
    send_command(KIND_ADD,    16'h0000, 8'h5A);
    send_command(KIND_KICK,   16'h1234, 8'hFF);
    send_command(KIND_REMOVE, 16'h4321, 8'h00);
    send_command(KIND_TICK,   16'hFFFF, 8'hFF);
    send_command(KIND_KICK,   16'h0000, 8'h00);
    send_command(KIND_TICK,   16'h0000, 8'h00);
    send_command(KIND_TICK,   16'h0000, 8'h00);
    send_command(KIND_REMOVE, 16'h0000, 8'hA5);
    send_command(KIND_TICK,   16'h0000, 8'h00);
    send_command(KIND_REMOVE, 16'hFFFF, 8'h00);
    send_command(KIND_REMOVE, 16'h0000, 8'h00);
    send_command(KIND_REMOVE, 16'h0000, 8'h00);
    send_command(KIND_KICK,   16'h0000, 8'h00);
    send_command(KIND_TICK,   16'h0000, 8'h00);

    // fill, churn without gaps, drain, then tick-heavy
    for (int phase = 0; phase < 4; phase++) begin
      no_gaps = (phase == 1);
      for (int n = 0; n < PhaseItems; n++)
        send_command(pick_kind(phase), pick_id(), 8'($urandom));
    end

    @(negedge clk);
    start = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d commands in directed and four random mixes", words_sent);
    $display("checked %0d result words: %0d expiries, %0d table-full answers",
             words_checked, expiries_seen, full_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
